### sv/aes128_pkg.sv
// Shared types, constants and byte functions for the AES-128 encryption block.
// Holds the fixed S-box table, the GF(2^8) doubling and the payload structs.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW    = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KEY_HIGH = 2'd0;
  localparam cfg_idx_t CFG_KEY_LOW  = 2'd1;

  localparam logic [7:0]        RCON_FIRST = 8'h01;
  localparam logic [7:0]        GF_POLY    = 8'h1b;
  localparam logic [RoundW-1:0] ROUND_LAST = RoundW'(NumRounds);

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes128_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes128_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // Multiplication by x in GF(2^8) with the AES reduction polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

### sv/aes128_key_step.sv
// One step of the AES-128 key schedule: derives round key r+1 from round key r.
// Depends on aes128_pkg for the S-box.
`timescale 1ns / 1ps

module aes128_key_step
  import aes128_pkg::*;
(
  input  logic [127:0] key_i,
  input  logic [7:0]   rcon_i,
  output logic [127:0] key_o
);

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] rot;
  logic [31:0] t;
  logic [31:0] n0, n1, n2, n3;

  assign {w0, w1, w2, w3} = key_i;
  assign rot = {w3[23:0], w3[31:24]};
  assign t   = {sub_byte(rot[31:24]) ^ rcon_i, sub_byte(rot[23:16]),
                sub_byte(rot[15:8]), sub_byte(rot[7:0])};

  assign n0 = w0 ^ t;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;

  assign key_o = {n0, n1, n2, n3};

endmodule

### sv/aes128_round.sv
// One AES round on a 128-bit state: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Byte 0 of the state sits in bits 127:120. Depends on aes128_pkg.
`timescale 1ns / 1ps

module aes128_round
  import aes128_pkg::*;
(
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  input  logic         last_i,
  output logic [127:0] state_o
);

  logic [7:0] in_b  [16];
  logic [7:0] sh_b  [16];
  logic [7:0] mix_b [16];
  logic [7:0] out_b [16];

  for (genvar k = 0; k < 16; k++) begin : g_bytes
    assign in_b[k] = state_i[127-8*k -: 8];
  end

  // Byte (col,row) takes the substituted byte from column (col+row) mod 4 of the same row.
  for (genvar c = 0; c < 4; c++) begin : g_shift_col
    for (genvar r = 0; r < 4; r++) begin : g_shift_row
      assign sh_b[4*c+r] = sub_byte(in_b[((c + r) % 4) * 4 + r]);
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_mix
    logic [7:0] all;
    assign all = sh_b[4*c] ^ sh_b[4*c+1] ^ sh_b[4*c+2] ^ sh_b[4*c+3];
    for (genvar r = 0; r < 4; r++) begin : g_mix_row
      assign mix_b[4*c+r] = sh_b[4*c+r] ^ all ^
                            xtime(sh_b[4*c+r] ^ sh_b[4*c+((r + 1) % 4)]);
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_out
    assign out_b[k] = (last_i ? sh_b[k] : mix_b[k]) ^ key_i[127-8*k -: 8];
    assign state_o[127-8*k -: 8] = out_b[k];
  end

endmodule

### sv/aes128_block_encrypt_top.sv
// AES-128 encryption engine, top level. Depends on aes128_pkg, aes128_round and
// aes128_key_step.
`timescale 1ns / 1ps

// A block accepted in idle is worked on in the run state, one round at a time; its
// ciphertext shows with done_o high after the last round, for exactly one cycle.
// A new block is taken only once the previous one is done, since the single round
// unit is used once per round; busy stays high while the rounds run.
// Reset clears the key to all zeros and returns the engine to idle; the receiver
// cannot stall, so each result is a transfer that completes in its strobe cycle.
module aes128_block_encrypt_top
  import aes128_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_t            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  aes128_in_t          block_i,
  output logic                done_o,
  output aes128_out_t         result_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

  // Key registers. Their contents form round key 0; later round keys are
  // derived on the fly, one schedule step per round, so no key store is kept.
  logic [63:0] key_high_q;
  logic [63:0] key_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  ctrl_state_e       state_q;
  logic [RoundW-1:0] round_q;
  logic [7:0]        rcon_q;
  logic [127:0]      data_q;
  logic [127:0]      rkey_q;
  logic              done_q;
  aes128_out_t       result_q;

  logic [127:0] rkey_next;
  logic [127:0] data_next;
  logic         last_round;
  logic         accept;

  assign accept     = start && (state_q == ST_IDLE);
  assign last_round = (round_q == ROUND_LAST);

  // The schedule step produces the key for the current round; the round unit
  // consumes it in the same cycle.
  aes128_key_step u_key_step (
    .key_i  (rkey_q),
    .rcon_i (rcon_q),
    .key_o  (rkey_next)
  );

  aes128_round u_round (
    .state_i (data_q),
    .key_i   (rkey_next),
    .last_i  (last_round),
    .state_o (data_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      round_q  <= '0;
      rcon_q   <= '0;
      data_q   <= '0;
      rkey_q   <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            // Initial AddRoundKey with the key registers as round key 0.
            data_q  <= {block_i.block_high, block_i.block_low} ^ {key_high_q, key_low_q};
            rkey_q  <= {key_high_q, key_low_q};
            rcon_q  <= RCON_FIRST;
            round_q <= RoundW'(1);
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          data_q  <= data_next;
          rkey_q  <= rkey_next;
          rcon_q  <= xtime(rcon_q);
          round_q <= round_q + RoundW'(1);
          if (last_round) begin
            // The result register is separate from the working state, so the
            // strobe cycle is unaffected by a block accepted right after it.
            result_q <= data_next;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy     = (state_q == ST_RUN);
  assign done_o   = done_q;
  assign result_o = result_q;

  // A result strobe only appears once the engine has gone back to idle.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while a block is in flight");

  // An accepted block starts at round one.
  a_accept_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN) && (round_q == RoundW'(1)))
    else $error("accepted block did not start at round one");

  // Finishing the last round raises the strobe on the next cycle.
  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && last_round |=> done_q)
    else $error("last round did not produce a result");

  // The round counter never leaves its range while running.
  a_round_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (round_q >= RoundW'(1)) && (round_q <= ROUND_LAST))
    else $error("round counter out of range");

  // The strobe lasts a single cycle per block.
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

endmodule

### tb/aes128_block_encrypt_checker.sv
// Checker for the AES-128 encryption engine: predicts each ciphertext and compares.
// Depends on aes128_pkg for the port types and the key register indexes only.
`timescale 1ns / 1ps

module aes128_block_encrypt_checker
  import aes128_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_t            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start_i,
  input  logic                busy_i,
  input  aes128_in_t          block_i,
  input  logic                done_i,
  input  aes128_out_t         result_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  logic [7:0]   sbox_tbl [256];
  logic [63:0]  key_high_q;
  logic [63:0]  key_low_q;
  logic [127:0] round_key [11];
  aes128_out_t  cipher_q [$];
  aes128_out_t  cipher_exp;
  int unsigned  mismatches;

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= sh;
      sh = gf_double(sh);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int unsigned n);
    logic [15:0] d;
    d = {b, b} << n;
    return d[15:8];
  endfunction

  // The substitution table is derived from first principles: the inverse is x^254,
  // which also maps zero to zero, followed by the affine map.
  function automatic void fill_sub_table();
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int p = 0; p < 254; p++) inv = gf_mul(inv, 8'(x));
      sbox_tbl[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
    end
  endfunction

  function automatic void expand_schedule(input logic [63:0] hi, input logic [63:0] lo);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rcon;
    w[0] = hi[63:32];
    w[1] = hi[31:0];
    w[2] = lo[63:32];
    w[3] = lo[31:0];
    rcon = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_tbl[t[31:24]], sbox_tbl[t[23:16]], sbox_tbl[t[15:8]], sbox_tbl[t[7:0]]}
            ^ {rcon, 24'h0};
        rcon = gf_double(rcon);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  // State byte k is block byte k; column c holds bytes 4c to 4c+3.
  function automatic aes128_out_t encrypt_block(input aes128_in_t blk);
    logic [7:0]   st [16];
    logic [7:0]   t [16];
    logic [127:0] flat;
    logic [7:0]   a0, a1, a2, a3, all;
    flat = blk;
    for (int k = 0; k < 16; k++) st[k] = flat[127-8*k -: 8] ^ round_key[0][127-8*k -: 8];
    for (int r = 1; r <= 10; r++) begin
      t = st;
      for (int row = 0; row < 4; row++)
        for (int col = 0; col < 4; col++)
          st[col*4+row] = sbox_tbl[t[((col + row) % 4)*4 + row]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0  = st[4*c];
          a1  = st[4*c+1];
          a2  = st[4*c+2];
          a3  = st[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
          st[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          st[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          st[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) st[k] ^= round_key[r][127-8*k -: 8];
    end
    for (int k = 0; k < 16; k++) flat[127-8*k -: 8] = st[k];
    return aes128_out_t'(flat);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_sub_table();
      key_high_q = '0;
      key_low_q  = '0;
      expand_schedule(key_high_q, key_low_q);
      cipher_q.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (done_i) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          $display("%0t: ciphertext with no block outstanding: expected none, got %h",
                   $time, result_i);
        end else begin
          cipher_exp = cipher_q.pop_front();
          if (result_i.cipher_high !== cipher_exp.cipher_high) begin
            mismatches++;
            $display("%0t: cipher_high mismatch: expected %h, got %h",
                     $time, cipher_exp.cipher_high, result_i.cipher_high);
          end
          if (result_i.cipher_low !== cipher_exp.cipher_low) begin
            mismatches++;
            $display("%0t: cipher_low mismatch: expected %h, got %h",
                     $time, cipher_exp.cipher_low, result_i.cipher_low);
          end
        end
      end
      if (start_i && !busy_i) cipher_q.push_back(encrypt_block(block_i));
      // Writes to an index other than the two key registers leave the key alone.
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_KEY_HIGH) begin
          key_high_q = cfg_data_i;
          expand_schedule(key_high_q, key_low_q);
        end else if (cfg_idx_i == CFG_KEY_LOW) begin
          key_low_q = cfg_data_i;
          expand_schedule(key_high_q, key_low_q);
        end
      end
      pending_o    <= cipher_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

### tb/aes128_block_encrypt_top_tb.sv
// Testbench top for the AES-128 encryption engine: reset, key setup and block stimulus.
// Depends on aes128_pkg, the engine RTL and aes128_block_encrypt_checker.
`timescale 1ns / 1ps

module aes128_block_encrypt_top_tb
  import aes128_pkg::*;
();

  // Register indexes that map to no key register; writes there must change nothing.
  localparam cfg_idx_t CfgIdxSpareA = 2'd2;
  localparam cfg_idx_t CfgIdxSpareB = 2'd3;

  localparam int unsigned RandomPhases  = 10;
  localparam int unsigned ItemsPerPhase = 105;
  localparam int unsigned QuietPhase    = 4;
  localparam int unsigned IdlePercent   = 7;
  localparam int unsigned MaxGap        = 14;
  localparam int unsigned DrainTail     = 4;
  localparam int unsigned ResultTail    = 16;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                start;
  logic                busy;
  aes128_in_t          block_in;
  logic                done;
  aes128_out_t         result;
  int unsigned         pending;
  int unsigned         fail_count;

  // Plaintext blocks waiting to be sent in the current phase.
  aes128_in_t plain_q [$];

  aes128_block_encrypt_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .start      (start),
    .busy       (busy),
    .block_i    (block_in),
    .done_o     (done),
    .result_o   (result)
  );

  aes128_block_encrypt_checker u_cipher_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .start_i      (start),
    .busy_i       (busy),
    .block_i      (block_in),
    .done_i       (done),
    .result_i     (result),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest legal run ends well before this timeout, so reaching it
  // means the engine has hung or lost a ciphertext.
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  // One key register write. The enable is then dropped before the next write so that
  // back-to-back writes never raise and lower it within the same time step.
  task automatic load_key_reg(input cfg_idx_t idx, input logic [63:0] data);
    cfg_idx  <= idx;
    cfg_data <= data;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Sends every queued block, then waits until the engine is idle with nothing
  // outstanding, so that the caller may change the key afterwards. Unless quiet is
  // set, the sender pauses now and then for a random number of cycles, so that
  // pauses land on every round of the engine's work.
  task automatic run_batch(input bit quiet);
    aes128_in_t  item;
    int unsigned gap;
    while (plain_q.size() != 0) begin
      item = plain_q.pop_front();
      if (!quiet && $urandom_range(99) < IdlePercent) begin
        gap = $urandom_range(MaxGap, 1);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      block_in <= item;
      start    <= 1'b1;
      // The transfer completes at the first edge that sees start high and busy low.
      do @(posedge clk); while (busy);
    end
    start <= 1'b0;
    // The checker's count is registered and lags behind its queue, which only makes this wait longer.
    do @(posedge clk); while (pending != 0 || busy);
    repeat (DrainTail) @(posedge clk);
  endtask

  initial begin
    // Every input is known from time zero, with reset held low at the start.
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_KEY_HIGH;
    cfg_data <= '0;
    start    <= 1'b0;
    block_in <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No key written yet: the engine must encrypt under the all-zero key.
    // Field extremes and alternating patterns exercise every data bit.
    plain_q.push_back('{block_high: 64'h0, block_low: 64'h0});
    plain_q.push_back('{block_high: '1, block_low: '1});
    plain_q.push_back('{block_high: 64'haaaa_aaaa_aaaa_aaaa, block_low: 64'h5555_5555_5555_5555});
    plain_q.push_back('{block_high: 64'h5555_5555_5555_5555, block_low: 64'haaaa_aaaa_aaaa_aaaa});
    plain_q.push_back('{block_high: 64'h8000_0000_0000_0000, block_low: 64'h0});
    plain_q.push_back('{block_high: 64'h0, block_low: 64'h0000_0000_0000_0001});
    run_batch(1'b0);

    // The standard test key, followed by writes to the unused indexes, which the
    // engine must ignore. The standard plaintext is then encrypted under it.
    load_key_reg(CFG_KEY_HIGH, 64'h0001_0203_0405_0607);
    load_key_reg(CFG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
    load_key_reg(CfgIdxSpareA, rand_word64());
    load_key_reg(CfgIdxSpareB, '1);
    plain_q.push_back('{block_high: 64'h0011_2233_4455_6677, block_low: 64'h8899_aabb_ccdd_eeff});
    plain_q.push_back('{block_high: 64'h0, block_low: 64'h0});
    run_batch(1'b0);

    // The all-ones key, the other extreme of both registers.
    load_key_reg(CFG_KEY_HIGH, '1);
    load_key_reg(CFG_KEY_LOW, '1);
    plain_q.push_back('{block_high: 64'h0, block_low: 64'h0});
    plain_q.push_back('{block_high: '1, block_low: '1});
    plain_q.push_back('{block_high: 64'h0011_2233_4455_6677, block_low: 64'h8899_aabb_ccdd_eeff});
    run_batch(1'b0);

    // Rewriting one register only: the key is the new low half with the old high half.
    load_key_reg(CFG_KEY_LOW, 64'h0);
    plain_q.push_back('{block_high: '1, block_low: '1});
    plain_q.push_back('{block_high: 64'h0, block_low: 64'h0});
    run_batch(1'b0);

    // Random phases. Each starts with a key change of a random kind while the engine
    // is idle; one phase runs with the sender never pausing.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case ($urandom_range(5))
        0: begin
          load_key_reg(CFG_KEY_HIGH, rand_word64());
          load_key_reg(CFG_KEY_LOW, rand_word64());
        end
        1: load_key_reg(CFG_KEY_HIGH, rand_word64());
        2: load_key_reg(CFG_KEY_LOW, rand_word64());
        3: begin
          load_key_reg(CFG_KEY_HIGH, '0);
          load_key_reg(CFG_KEY_LOW, '0);
        end
        4: begin
          load_key_reg(CFG_KEY_HIGH, '1);
          load_key_reg(CFG_KEY_LOW, '1);
        end
        default: begin
          load_key_reg($urandom_range(1) ? CfgIdxSpareA : CfgIdxSpareB, rand_word64());
          load_key_reg(CFG_KEY_LOW, rand_word64());
        end
      endcase
      // Mostly dense random plaintext, with a share of extremes and one-hot or
      // one-cold blocks that stress single-bit diffusion.
      for (int n = 0; n < ItemsPerPhase; n++) begin
        case ($urandom_range(15))
          0: plain_q.push_back(aes128_in_t'(128'h0));
          1: plain_q.push_back(aes128_in_t'({128{1'b1}}));
          2: plain_q.push_back(aes128_in_t'(128'h1 << $urandom_range(127)));
          3: plain_q.push_back(aes128_in_t'(~(128'h1 << $urandom_range(127))));
          default: plain_q.push_back(aes128_in_t'({rand_word64(), rand_word64()}));
        endcase
      end
      run_batch(ph == QuietPhase);
    end

    // All ciphertexts are in; allow a few more cycles in case the engine strobes
    // a result that nothing asked for.
    repeat (ResultTail) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
sv/aes128_pkg.sv
sv/aes128_key_step.sv
sv/aes128_round.sv
sv/aes128_block_encrypt_top.sv
tb/aes128_block_encrypt_checker.sv
tb/aes128_block_encrypt_top_tb.sv
